// ----- sv/seek_arrive_steering_assert.svh -----
// assertion helpers for the steering block
`ifndef SEEK_ARRIVE_STEERING_ASSERT_SVH
`define SEEK_ARRIVE_STEERING_ASSERT_SVH

// condition holds in the same cycle
`define SAS_CHECK(label, clk, rst_n, pre, post) \
label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("steering assertion failed");

// condition holds in the following cycle
`define SAS_CHECK_NEXT(label, clk, rst_n, pre, post) \
label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("steering assertion failed");

`endif

// ----- sv/sas_pkg.sv -----
package sas_pkg;

	localparam int COORD_W    = 24;
	localparam int CFG_W      = 23;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int ROOT_W     = DIFF_W;
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int SQR_W      = SQ_W + 1;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int PROD_W     = DIFF_W + CFG_W;
	localparam int DES_QW     = CFG_W;
	localparam int CLP_QW     = DIFF_W;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [2:0][COORD_W-1:0] vec_t;
	typedef logic [CFG_W-1:0] cfg_t;

	typedef enum logic [1:0] {
		CFG_MAX_SPEED = 2'd0,
		CFG_MAX_FORCE = 2'd1,
		CFG_APPROACH  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [SQR_W-1:0] x;
		logic [SQR_W-1:0] r;
	} sqrt_t;

	// item handed from front to back
	typedef struct packed {
		logic [2:0]             neg;
		logic [2:0][DIFF_W-1:0] mag;
		vec_t                   vel;
		logic                   arriving;
		logic [ROOT_W-1:0]      den;
	} arr_t;

	typedef struct packed {
		logic [2:0]             neg;
		logic [2:0][DIFF_W-1:0] mag;
		vec_t                   vel;
		logic [2:0][SQ_W-1:0]   sq;
		sqrt_t                  sr;
		logic                   arriving;
		logic [ROOT_W-1:0]      den;
	} fe_t;

	typedef struct packed {
		logic [2:0]             neg;
		vec_t                   vel;
		logic                   arriving;
		logic [ROOT_W-1:0]      den;
		logic                   dz;
		logic [2:0][PROD_W-1:0] prod;
		logic [2:0][ROOT_W-1:0] rem;
		logic [2:0][DES_QW-1:0] q;
		logic [2:0][DIFF_W-1:0] s;
		logic [2:0]             sneg;
		logic [2:0][DIFF_W-1:0] smag;
		logic [2:0][SQ_W-1:0]   sq;
		sqrt_t                  sr;
		logic                   clamped;
		logic [ROOT_W-1:0]      cmag;
		logic [1:0][PROD_W-1:0] cprod;
		logic [1:0][ROOT_W-1:0] crem;
		logic [1:0][CLP_QW-1:0] cq;
		logic [1:0][COORD_W-1:0] res;
	} be_t;

	function automatic sqrt_t sqrt_step(sqrt_t a, int unsigned sh);
		logic [SQR_W-1:0] b;
		sqrt_t o;
		b = SQR_W'(1) << sh;
		if (a.x >= a.r + b) begin
			o.x = a.x - (a.r + b);
			o.r = (a.r >> 1) + b;
		end else begin
			o.x = a.x;
			o.r = a.r >> 1;
		end
		return o;
	endfunction

	// one restoring division step, returns {quotient bit, remainder}
	function automatic logic [ROOT_W:0] div_step(logic [ROOT_W-1:0] rem, logic nb,
		logic [ROOT_W-1:0] den);
		logic [ROOT_W:0] t;
		logic [ROOT_W:0] d;
		t = {rem, nb};
		d = {1'b0, den};
		if (t >= d) begin
			return {1'b1, ROOT_W'(t - d)};
		end else begin
			return {1'b0, t[ROOT_W-1:0]};
		end
	endfunction

endpackage

// ----- sv/sas_fifo.sv -----
`include "seek_arrive_steering_assert.svh"

module sas_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sas_pkg::arr_t in_item,
	output logic          out_valid,
	input  logic          out_ready,
	output sas_pkg::arr_t out_item
);
	import sas_pkg::*;

	arr_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW:0]   cnt_q;
	logic               push;
	logic               pop;

	assign in_ready  = cnt_q != (FIFO_AW + 1)'(FIFO_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_item  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`SAS_CHECK(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= (FIFO_AW + 1)'(FIFO_DEPTH))
	`SAS_CHECK(a_ptr_gap, clk, arst_n, 1'b1, (wr_q - rd_q) == cnt_q[FIFO_AW-1:0])
	`SAS_CHECK_NEXT(a_push_only, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1)
	`SAS_CHECK_NEXT(a_pop_only, clk, arst_n, pop && !push, cnt_q == $past(cnt_q) - 1'b1)

endmodule

// ----- sv/sas_front.sv -----
module sas_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sas_pkg::vec_t pos,
	input  sas_pkg::vec_t vel,
	input  sas_pkg::vec_t target,
	input  sas_pkg::cfg_t approach_distance,
	output logic          out_valid,
	input  logic          out_ready,
	output sas_pkg::arr_t out_item
);
	import sas_pkg::*;

	localparam int F_SQ    = 1;
	localparam int F_SUM   = F_SQ + 1;
	localparam int F_SQRT0 = F_SUM + 1;
	localparam int F_LAST  = F_SQRT0 + SQRT_STEPS;
	localparam int F_N     = F_LAST + 1;

	fe_t            pipe_q [F_N];
	fe_t            nx [F_N];
	logic [F_N-1:0] vld_q;
	logic           adv;

	assign adv       = !vld_q[F_N-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[F_N-1];

	assign out_item.neg      = pipe_q[F_LAST].neg;
	assign out_item.mag      = pipe_q[F_LAST].mag;
	assign out_item.vel      = pipe_q[F_LAST].vel;
	assign out_item.arriving = pipe_q[F_LAST].arriving;
	assign out_item.den      = pipe_q[F_LAST].den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[F_N-2:0], in_valid};
		end
	end

	for (genvar k = 0; k < F_N; k++) begin : g_stage
		always_ff @(posedge clk) begin
			if (adv) begin
				pipe_q[k] <= nx[k];
			end
		end

		if (k == 0) begin : g_diff
			always_comb begin
				logic signed [DIFF_W-1:0] d;
				nx[k]     = '0;
				nx[k].vel = vel;
				for (int i = 0; i < 3; i++) begin
					d = $signed({target[i][COORD_W-1], target[i]})
						- $signed({pos[i][COORD_W-1], pos[i]});
					nx[k].neg[i] = d[DIFF_W-1];
					nx[k].mag[i] = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
				end
			end
		end else if (k == F_SQ) begin : g_sq
			always_comb begin
				nx[k] = pipe_q[k-1];
				for (int i = 0; i < 3; i++) begin
					nx[k].sq[i] = SQ_W'(pipe_q[k-1].mag[i]) * SQ_W'(pipe_q[k-1].mag[i]);
				end
			end
		end else if (k == F_SUM) begin : g_sum
			always_comb begin
				nx[k]      = pipe_q[k-1];
				nx[k].sr.x = SQR_W'(pipe_q[k-1].sq[0]) + SQR_W'(pipe_q[k-1].sq[1])
					+ SQR_W'(pipe_q[k-1].sq[2]);
				nx[k].sr.r = '0;
			end
		end else if (k < F_LAST) begin : g_sqrt
			always_comb begin
				nx[k]    = pipe_q[k-1];
				nx[k].sr = sqrt_step(pipe_q[k-1].sr, 2 * (SQRT_STEPS - 1 - (k - F_SQRT0)));
			end
		end else begin : g_class
			always_comb begin
				logic [ROOT_W-1:0] len;
				len            = pipe_q[k-1].sr.r[ROOT_W-1:0];
				nx[k]          = pipe_q[k-1];
				nx[k].arriving = len < ROOT_W'(approach_distance);
				nx[k].den      = nx[k].arriving ? ROOT_W'(approach_distance) : len;
			end
		end
	end

endmodule

// ----- sv/sas_back.sv -----
module sas_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sas_pkg::arr_t  in_item,
	input  sas_pkg::cfg_t  max_speed,
	input  sas_pkg::cfg_t  max_force,
	output logic           out_valid,
	input  logic           out_ready,
	output sas_pkg::coord_t steer_x,
	output sas_pkg::coord_t steer_y,
	output logic           arriving,
	output logic           clamped
);
	import sas_pkg::*;

	localparam int B_DIV0  = 1;
	localparam int B_SUB   = B_DIV0 + DES_QW;
	localparam int B_SQ    = B_SUB + 1;
	localparam int B_SUM   = B_SQ + 1;
	localparam int B_SQRT0 = B_SUM + 1;
	localparam int B_CLP   = B_SQRT0 + SQRT_STEPS;
	localparam int B_CDIV0 = B_CLP + 1;
	localparam int B_OUT   = B_CDIV0 + CLP_QW;
	localparam int B_N     = B_OUT + 1;

	be_t            pipe_q [B_N];
	be_t            nx [B_N];
	logic [B_N-1:0] vld_q;
	logic           adv;

	assign adv       = !vld_q[B_N-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[B_N-1];
	assign steer_x   = pipe_q[B_OUT].res[0];
	assign steer_y   = pipe_q[B_OUT].res[1];
	assign arriving  = pipe_q[B_OUT].arriving;
	assign clamped   = pipe_q[B_OUT].clamped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[B_N-2:0], in_valid};
		end
	end

	for (genvar k = 0; k < B_N; k++) begin : g_stage
		always_ff @(posedge clk) begin
			if (adv) begin
				pipe_q[k] <= nx[k];
			end
		end

		if (k == 0) begin : g_mul
			always_comb begin
				nx[k]          = '0;
				nx[k].neg      = in_item.neg;
				nx[k].vel      = in_item.vel;
				nx[k].arriving = in_item.arriving;
				nx[k].den      = in_item.den;
				nx[k].dz       = in_item.den == '0;
				for (int i = 0; i < 3; i++) begin
					nx[k].prod[i] = PROD_W'(in_item.mag[i]) * PROD_W'(max_speed);
					nx[k].rem[i]  = nx[k].prod[i][PROD_W-1:DES_QW];
				end
			end
		end else if (k < B_SUB) begin : g_div
			always_comb begin
				logic [ROOT_W:0] st;
				nx[k] = pipe_q[k-1];
				for (int i = 0; i < 3; i++) begin
					st = div_step(pipe_q[k-1].rem[i],
						pipe_q[k-1].prod[i][DES_QW-1-(k-B_DIV0)], pipe_q[k-1].den);
					nx[k].rem[i] = st[ROOT_W-1:0];
					nx[k].q[i]   = {pipe_q[k-1].q[i][DES_QW-2:0], st[ROOT_W]};
				end
			end
		end else if (k == B_SUB) begin : g_sub
			always_comb begin
				logic signed [DIFF_W-1:0] des;
				logic signed [DIFF_W-1:0] s;
				logic [DIFF_W-1:0]        qv;
				nx[k] = pipe_q[k-1];
				for (int i = 0; i < 3; i++) begin
					qv  = pipe_q[k-1].dz ? '0 : DIFF_W'(pipe_q[k-1].q[i]);
					des = pipe_q[k-1].neg[i] ? -$signed(qv) : $signed(qv);
					s   = des - $signed({pipe_q[k-1].vel[i][COORD_W-1], pipe_q[k-1].vel[i]});
					nx[k].s[i]    = s;
					nx[k].sneg[i] = s[DIFF_W-1];
					nx[k].smag[i] = s[DIFF_W-1] ? DIFF_W'(-s) : DIFF_W'(s);
				end
			end
		end else if (k == B_SQ) begin : g_sq
			always_comb begin
				nx[k] = pipe_q[k-1];
				for (int i = 0; i < 3; i++) begin
					nx[k].sq[i] = SQ_W'(pipe_q[k-1].smag[i]) * SQ_W'(pipe_q[k-1].smag[i]);
				end
			end
		end else if (k == B_SUM) begin : g_sum
			always_comb begin
				nx[k]      = pipe_q[k-1];
				nx[k].sr.x = SQR_W'(pipe_q[k-1].sq[0]) + SQR_W'(pipe_q[k-1].sq[1])
					+ SQR_W'(pipe_q[k-1].sq[2]);
				nx[k].sr.r = '0;
			end
		end else if (k < B_CLP) begin : g_sqrt
			always_comb begin
				nx[k]    = pipe_q[k-1];
				nx[k].sr = sqrt_step(pipe_q[k-1].sr, 2 * (SQRT_STEPS - 1 - (k - B_SQRT0)));
			end
		end else if (k == B_CLP) begin : g_clp
			always_comb begin
				nx[k]         = pipe_q[k-1];
				nx[k].cmag    = pipe_q[k-1].sr.r[ROOT_W-1:0];
				nx[k].clamped = nx[k].cmag > ROOT_W'(max_force);
				for (int i = 0; i < 2; i++) begin
					nx[k].cprod[i] = PROD_W'(pipe_q[k-1].smag[i]) * PROD_W'(max_force);
					nx[k].crem[i]  = ROOT_W'(nx[k].cprod[i][PROD_W-1:CLP_QW]);
					nx[k].cq[i]    = '0;
				end
			end
		end else if (k < B_OUT) begin : g_cdiv
			always_comb begin
				logic [ROOT_W:0] st;
				nx[k] = pipe_q[k-1];
				for (int i = 0; i < 2; i++) begin
					st = div_step(pipe_q[k-1].crem[i],
						pipe_q[k-1].cprod[i][CLP_QW-1-(k-B_CDIV0)], pipe_q[k-1].cmag);
					nx[k].crem[i] = st[ROOT_W-1:0];
					nx[k].cq[i]   = {pipe_q[k-1].cq[i][CLP_QW-2:0], st[ROOT_W]};
				end
			end
		end else begin : g_out
			always_comb begin
				logic signed [DIFF_W:0] v;
				logic signed [DIFF_W:0] cv;
				nx[k] = pipe_q[k-1];
				for (int i = 0; i < 2; i++) begin
					cv = $signed({1'b0, pipe_q[k-1].cq[i]});
					if (pipe_q[k-1].clamped) begin
						v = pipe_q[k-1].sneg[i] ? -cv : cv;
					end else begin
						v = $signed({pipe_q[k-1].s[i][DIFF_W-1], pipe_q[k-1].s[i]});
					end
					if (v[DIFF_W] == v[DIFF_W-1] && v[DIFF_W-1] == v[COORD_W-1]) begin
						nx[k].res[i] = v[COORD_W-1:0];
					end else if (v[DIFF_W]) begin
						nx[k].res[i] = {1'b1, {(COORD_W-1){1'b0}}};
					end else begin
						nx[k].res[i] = {1'b0, {(COORD_W-1){1'b1}}};
					end
				end
			end
		end
	end

endmodule

// ----- sv/seek_arrive_steering.sv -----
// Seek-with-arrival steering, one agent update per transaction. Accepts one
// transaction per clock while the input is not stalled, and returns one result
// per transaction, in order. A transaction passes through 29 front stages
// (offset, squares, one root bit per stage, arrival test), the four-entry
// queue, and 79 back stages (restoring divider with one quotient bit per
// stage, steering, square root, clamp divider, saturation).
// A stalled output holds the back section; the queue then absorbs up to four
// transactions before the front section and the input stall as well.
// Configuration writes take effect at once and are acknowledged every cycle;
// register index 3 is ignored.
module seek_arrive_steering (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sas_pkg::coord_t pos_x,
	input  sas_pkg::coord_t pos_y,
	input  sas_pkg::coord_t pos_z,
	input  sas_pkg::coord_t vel_x,
	input  sas_pkg::coord_t vel_y,
	input  sas_pkg::coord_t vel_z,
	input  sas_pkg::coord_t target_x,
	input  sas_pkg::coord_t target_y,
	input  sas_pkg::coord_t target_z,
	output logic            out_valid,
	input  logic            out_ready,
	output sas_pkg::coord_t steer_x,
	output sas_pkg::coord_t steer_y,
	output logic            arriving,
	output logic            clamped,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  sas_pkg::cfg_t   cfg_data
);
	import sas_pkg::*;

	cfg_t max_speed_q;
	cfg_t max_force_q;
	cfg_t approach_q;
	arr_t fe_item;
	arr_t be_item;
	logic fe_valid;
	logic fe_ready;
	logic be_valid;
	logic be_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= CFG_W'(12800);
			max_force_q <= CFG_W'(256);
			approach_q  <= CFG_W'(76800);
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MAX_SPEED: max_speed_q <= cfg_data;
				CFG_MAX_FORCE: max_force_q <= cfg_data;
				CFG_APPROACH:  approach_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	sas_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.pos               ({pos_z, pos_y, pos_x}),
		.vel               ({vel_z, vel_y, vel_x}),
		.target            ({target_z, target_y, target_x}),
		.approach_distance (approach_q),
		.out_valid         (fe_valid),
		.out_ready         (fe_ready),
		.out_item          (fe_item)
	);

	sas_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fe_valid),
		.in_ready  (fe_ready),
		.in_item   (fe_item),
		.out_valid (be_valid),
		.out_ready (be_ready),
		.out_item  (be_item)
	);

	sas_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (be_valid),
		.in_ready  (be_ready),
		.in_item   (be_item),
		.max_speed (max_speed_q),
		.max_force (max_force_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.steer_x   (steer_x),
		.steer_y   (steer_y),
		.arriving  (arriving),
		.clamped   (clamped)
	);

endmodule
